>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
// The clocked form is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define B64D_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("assertion failed");
`define B64D_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");
`else
`define B64D_ASSERT(lbl, clk, rst_n, prop)
`define B64D_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

>>> hw/rtl/b64d_pkg.sv
package b64d_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_DONE  = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    localparam logic [7:0] CHAR_PAD = 8'h3D;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    localparam int MAX_PUSH   = 3;
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_PTR_W = 3;
    localparam int FIFO_CNT_W = 4;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [15:0] byte_count;
        logic        last;
    } t_result;

    typedef struct packed {
        logic [1:0]         num;
        t_result [2:0]      res;
    } t_push;

    typedef struct packed {
        logic       valid;
        logic [5:0] value;
    } t_sextet;

    function automatic t_sextet sextet_of(input logic [7:0] ch);
        t_sextet s;
        s.valid = 1'b1;
        s.value = 6'd0;
        if (ch >= 8'h41 && ch <= 8'h5A) begin
            s.value = 6'(ch - 8'h41);
        end else if (ch >= 8'h61 && ch <= 8'h7A) begin
            s.value = 6'(ch - 8'h47);
        end else if (ch >= 8'h30 && ch <= 8'h39) begin
            s.value = 6'(ch + 8'h04);
        end else if (ch == 8'h2B) begin
            s.value = 6'd62;
        end else if (ch == 8'h2F) begin
            s.value = 6'd63;
        end else begin
            s.valid = 1'b0;
        end
        return s;
    endfunction

endpackage

>>> hw/rtl/b64d_in_if.sv
interface b64d_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       terminator;

    modport source (output valid, output character, output terminator, input ready);
    modport sink (input valid, input character, input terminator, output ready);
endinterface

>>> hw/rtl/b64d_out_if.sv
interface b64d_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  data_byte;
    logic [15:0] byte_count;
    logic        last;

    modport source (output valid, output kind, output data_byte, output byte_count,
                    output last, input ready);
    modport sink (input valid, input kind, input data_byte, input byte_count,
                  input last, output ready);
endinterface

>>> hw/rtl/b64d_decode.sv
`include "assert_macros.svh"

module b64d_decode
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_character,
    input  logic       i_terminator,
    output t_push      o_push
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic [1:0]             r_pos;
    logic [23:0]            r_bits;
    logic [2:0]             r_pad;
    logic                   r_stopped;
    logic                   r_error;
    logic [COUNT_WIDTH-1:0] r_total;

    logic [1:0]             n_pos;
    logic [23:0]            n_bits;
    logic [2:0]             n_pad;
    logic                   n_stopped;
    logic                   n_error;
    logic [COUNT_WIDTH-1:0] n_total;

    logic                   term;
    logic                   is_pad;
    t_sextet                sx;
    logic [23:0]            shifted;
    logic [2:0]             pad_next;
    logic [1:0]             nbytes;
    logic [COUNT_WIDTH:0]   sum;
    logic [31:0]            total_ext;
    t_push                  push;

    assign term      = i_terminator || (i_character == CHAR_NUL);
    assign is_pad    = (i_character == CHAR_PAD);
    assign sx        = sextet_of(i_character);
    assign shifted   = {r_bits[17:0], (is_pad ? 6'd0 : sx.value)};
    assign pad_next  = is_pad ? r_pad + 3'd1 : r_pad;
    assign nbytes    = (pad_next > 3'd2) ? 2'd0 : 2'(3'd3 - pad_next);
    assign sum       = {1'b0, r_total} + (COUNT_WIDTH + 1)'(nbytes);
    assign total_ext = 32'(r_total);

    always_comb begin
        n_pos     = r_pos;
        n_bits    = r_bits;
        n_pad     = r_pad;
        n_stopped = r_stopped;
        n_error   = r_error;
        n_total   = r_total;
        push      = '0;
        if (i_accept) begin
            if (term) begin
                push.num = 2'd1;
                if (r_error || (!r_stopped && r_pos != 2'd0)) begin
                    push.res[0].kind = KIND_ERROR;
                end else begin
                    push.res[0].kind       = KIND_DONE;
                    push.res[0].byte_count = total_ext[15:0];
                end
                push.res[0].last = 1'b1;
                n_pos     = 2'd0;
                n_bits    = '0;
                n_pad     = '0;
                n_stopped = 1'b0;
                n_error   = 1'b0;
                n_total   = '0;
            end else if (!r_stopped && !r_error) begin
                if (r_pos == 2'd0 && !is_pad && !sx.valid) begin
                    n_stopped = 1'b1;
                end else if (!is_pad && (r_pad != 3'd0 || !sx.valid)) begin
                    n_error = 1'b1;
                end else if (r_pos != 2'd3) begin
                    n_pos  = r_pos + 2'd1;
                    n_bits = shifted;
                    n_pad  = pad_next;
                end else begin
                    n_pos  = 2'd0;
                    n_bits = '0;
                    n_pad  = '0;
                    if (nbytes == 2'd0) begin
                        n_error = 1'b1;
                    end else begin
                        push.num = nbytes;
                        for (int k = 0; k < MAX_PUSH; k++) begin
                            push.res[k].kind      = KIND_DATA;
                            push.res[k].data_byte = shifted[23 - 8 * k -: 8];
                            push.res[k].last      = (2'(k) == nbytes - 2'd1);
                        end
                        n_total = sum[COUNT_WIDTH] ? CountMax : sum[COUNT_WIDTH-1:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= 2'd0;
            r_bits    <= '0;
            r_pad     <= '0;
            r_stopped <= 1'b0;
            r_error   <= 1'b0;
            r_total   <= '0;
        end else begin
            r_pos     <= n_pos;
            r_bits    <= n_bits;
            r_pad     <= n_pad;
            r_stopped <= n_stopped;
            r_error   <= n_error;
            r_total   <= n_total;
        end
    end

    assign o_push = push;

    // Stopping and an error both freeze the group, so they never coexist.
    `B64D_ASSERT(a_stop_err_excl, i_clk, i_rst_n, !(r_stopped && r_error))
    `B64D_ASSERT(a_term_clears, i_clk, i_rst_n,
        (i_accept && term) |=> (r_pos == 2'd0 && !r_stopped && !r_error && r_total == '0))
    `B64D_ASSERT(a_pad_bound, i_clk, i_rst_n, r_pad <= 3'd3)

endmodule

>>> hw/rtl/b64d_fifo.sv
`include "assert_macros.svh"

module b64d_fifo
    import b64d_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_push       i_push,
    output logic        o_space,
    b64d_out_if.source  o_out
);

    t_result                r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0]  r_wr_ptr;
    logic [FIFO_PTR_W-1:0]  r_rd_ptr;
    logic [FIFO_CNT_W-1:0]  r_count;

    logic [FIFO_PTR_W-1:0]  n_wr_ptr;
    logic [FIFO_PTR_W-1:0]  n_rd_ptr;
    logic [FIFO_CNT_W-1:0]  n_count;

    logic                   pop;
    t_result                head;

    assign pop  = o_out.valid && o_out.ready;
    assign head = r_mem[r_rd_ptr];

    assign n_wr_ptr = r_wr_ptr + FIFO_PTR_W'(i_push.num);
    assign n_rd_ptr = r_rd_ptr + FIFO_PTR_W'(pop);
    assign n_count  = r_count + FIFO_CNT_W'(i_push.num) - FIFO_CNT_W'(pop);

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PUSH; k++) begin
            if (2'(k) < i_push.num) begin
                r_mem[r_wr_ptr + FIFO_PTR_W'(k)] <= i_push.res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    assign o_space          = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH));
    assign o_out.valid      = (r_count != '0);
    assign o_out.kind       = head.kind;
    assign o_out.data_byte  = head.data_byte;
    assign o_out.byte_count = head.byte_count;
    assign o_out.last       = head.last;

    `B64D_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= FIFO_CNT_W'(FIFO_DEPTH))
    `B64D_ASSERT(a_no_overflow, i_clk, i_rst_n,
        (i_push.num != 2'd0) |-> (r_count <= FIFO_CNT_W'(FIFO_DEPTH - MAX_PUSH)))
    `B64D_ASSERT(a_drain_empty, i_clk, i_rst_n,
        (pop && r_count == FIFO_CNT_W'(1) && i_push.num == 2'd0) |=> !o_out.valid)

endmodule

>>> hw/rtl/base64_decoder.sv
// Streaming base64 decoder.
// The input channel takes one request per character: an 8-bit character and a
// terminator flag. A character of value zero also ends the string.
// The output channel gives one request per result: a data byte, a done result
// with the decoded byte count, or an error result; last marks the final result
// caused by one input request.
// A complete group of four characters gives up to three data bytes; a
// terminator gives exactly one done or error result and clears the decoder.
// Results enter an eight-entry result queue in the cycle after acceptance.
// One character is accepted every cycle while the queue has room for three
// more results; while the receiver is ready, the queue drains one result per
// cycle, keeping up with the three bytes that every four characters produce.
// When the receiver stalls, the queue fills and input ready drops once fewer
// than three entries are free; no result is lost.
// A synchronous active-low reset empties the queue and clears the group,
// the pad and error flags and the byte count.
module base64_decoder
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    b64d_in_if.sink     i_in,
    b64d_out_if.source  o_out
);

    logic  accept;
    logic  space;
    t_push push;

    assign i_in.ready = space;
    assign accept     = i_in.valid && space;

    b64d_decode #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_character  (i_in.character),
        .i_terminator (i_in.terminator),
        .o_push       (push)
    );

    b64d_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_space (space),
        .o_out   (o_out)
    );

endmodule

>>> tb/b64d_result_checker.sv
`timescale 1ns / 100ps

module b64d_result_checker
    import b64d_pkg::*;
#(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_char_valid,
    input  logic        i_char_ready,
    input  logic [7:0]  i_character,
    input  logic        i_terminator,
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_data_byte,
    input  logic [15:0] i_byte_count,
    input  logic        i_last,
    output int          o_mismatch_count,
    output int          o_pending
);

    localparam logic [32:0] COUNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;
    localparam int PRINT_LIMIT = 100;

    string       b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    int          sextet_lut [256];
    t_result     expected_results [$];

    logic [1:0]  grp_pos;
    logic [23:0] grp_bits;
    logic [2:0]  pad_cnt;
    logic        halted;
    logic        err_seen;
    logic [32:0] bytes_total;

    initial begin
        o_mismatch_count = 0;
        o_pending = 0;
        for (int i = 0; i < 256; i++) begin
            sextet_lut[i] = -1;
        end
        for (int i = 0; i < 64; i++) begin
            sextet_lut[b64_alphabet[i]] = i;
        end
    end

    task automatic clear_decoder();
        grp_pos = '0;
        grp_bits = '0;
        pad_cnt = '0;
        halted = 1'b0;
        err_seen = 1'b0;
        bytes_total = '0;
    endtask

    task automatic push_result(input t_kind kind, input logic [7:0] data_byte,
                               input logic [15:0] byte_count, input logic last);
        t_result res;
        res.kind = kind;
        res.data_byte = data_byte;
        res.byte_count = byte_count;
        res.last = last;
        expected_results.push_back(res);
    endtask

    task automatic decode_char(input logic [7:0] ch, input logic term);
        int value;
        int nbytes;
        value = sextet_lut[ch];
        if (term || ch == CHAR_NUL) begin
            if (err_seen || (!halted && grp_pos != 0)) begin
                push_result(KIND_ERROR, 8'd0, 16'd0, 1'b1);
            end else begin
                push_result(KIND_DONE, 8'd0, bytes_total[15:0], 1'b1);
            end
            clear_decoder();
            return;
        end
        if (halted || err_seen) begin
            return;
        end
        if (grp_pos == 0 && ch != CHAR_PAD && value < 0) begin
            halted = 1'b1;
            return;
        end
        if (ch == CHAR_PAD) begin
            pad_cnt = pad_cnt + 3'd1;
            grp_bits = {grp_bits[17:0], 6'd0};
        end else if (pad_cnt != 0 || value < 0) begin
            err_seen = 1'b1;
            return;
        end else begin
            grp_bits = {grp_bits[17:0], 6'(value)};
        end
        if (grp_pos < 3) begin
            grp_pos = grp_pos + 2'd1;
            return;
        end
        if (pad_cnt > 2) begin
            err_seen = 1'b1;
        end else begin
            nbytes = 3 - int'(pad_cnt);
            for (int i = 0; i < nbytes; i++) begin
                push_result(KIND_DATA, grp_bits[23 - 8 * i -: 8], 16'd0, i == nbytes - 1);
                if (bytes_total < COUNT_MAX) begin
                    bytes_total = bytes_total + 33'd1;
                end
            end
        end
        grp_pos = '0;
        grp_bits = '0;
        pad_cnt = '0;
    endtask

    // Printing stops after a bound so that a badly broken run stays readable.
    task automatic report_mismatch(input string what, input int exp_val, input int got_val);
        if (o_mismatch_count < PRINT_LIMIT) begin
            $display("%0t: mismatch on %s: expected %0d, got %0d",
                     $realtime, what, exp_val, got_val);
        end
        o_mismatch_count++;
    endtask

    task automatic check_result();
        t_result exp_res;
        if (expected_results.size() == 0) begin
            report_mismatch("result with nothing outstanding, kind", -1, i_kind);
            return;
        end
        exp_res = expected_results.pop_front();
        if (i_kind != exp_res.kind) begin
            report_mismatch("kind", exp_res.kind, i_kind);
        end
        if (i_data_byte != exp_res.data_byte) begin
            report_mismatch("data_byte", exp_res.data_byte, i_data_byte);
        end
        if (i_byte_count != exp_res.byte_count) begin
            report_mismatch("byte_count", exp_res.byte_count, i_byte_count);
        end
        if (i_last != exp_res.last) begin
            report_mismatch("last", exp_res.last, i_last);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            expected_results.delete();
        end else begin
            if (i_char_valid && i_char_ready) begin
                decode_char(i_character, i_terminator);
            end
            if (i_res_valid && i_res_ready) begin
                check_result();
            end
        end
        o_pending = expected_results.size();
    end

endmodule

>>> tb/tb_base64_decoder.sv
`timescale 1ns / 100ps

module tb_base64_decoder
    import b64d_pkg::*;
();

    localparam int COUNT_W = 8;
    localparam int STALL_CYCLES = 80;
    localparam int IDLE_PERCENT = 28;
    localparam int RANDOM_CHARS = 55;
    localparam int STALL_GROUPS = 6;

    logic  i_clk;
    logic  i_rst_n;
    int    mismatch_count;
    int    pending;
    bit    idle_on = 1'b1;
    bit    hold_toggle = 1'b0;
    int    sent_chars = 0;
    string b64_alphabet =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    b64d_in_if  char_ch ();
    b64d_out_if result_ch ();

    base64_decoder #(
        .COUNT_WIDTH(COUNT_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (char_ch),
        .o_out   (result_ch)
    );

    b64d_result_checker #(
        .COUNT_WIDTH(COUNT_W)
    ) result_check (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_char_valid     (char_ch.valid),
        .i_char_ready     (char_ch.ready),
        .i_character      (char_ch.character),
        .i_terminator     (char_ch.terminator),
        .i_res_valid      (result_ch.valid),
        .i_res_ready      (result_ch.ready),
        .i_kind           (result_ch.kind),
        .i_data_byte      (result_ch.data_byte),
        .i_byte_count     (result_ch.byte_count),
        .i_last           (result_ch.last),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #2 i_clk = ~i_clk;
        end
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // The receiver holds off for a long stretch each time hold_toggle flips.
    initial begin
        int hold_left;
        bit seen_toggle;
        hold_left = 0;
        seen_toggle = 1'b0;
        result_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_toggle != seen_toggle) begin
                seen_toggle = hold_toggle;
                hold_left = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                result_ch.ready <= 1'b0;
                hold_left--;
            end else if (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
                result_ch.ready <= 1'b0;
            end else begin
                result_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [7:0] rand_b64();
        return b64_alphabet[$urandom_range(0, 63)];
    endfunction

    task automatic send_char(input logic [7:0] ch, input logic term);
        while (idle_on && $urandom_range(0, 99) < IDLE_PERCENT) begin
            char_ch.valid <= 1'b0;
            char_ch.character <= 8'($urandom);
            char_ch.terminator <= 1'($urandom);
            @(negedge i_clk);
        end
        char_ch.valid <= 1'b1;
        char_ch.character <= ch;
        char_ch.terminator <= term;
        @(posedge i_clk);
        while (!char_ch.ready) begin
            @(posedge i_clk);
        end
        sent_chars++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) begin
            send_char(text[i], 1'b0);
        end
    endtask

    task automatic send_end();
        if ($urandom_range(0, 1) == 1) begin
            send_char(8'($urandom), 1'b1);
        end else begin
            send_char(CHAR_NUL, 1'b0);
        end
    endtask

    task automatic wait_drained();
        char_ch.valid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_idling(input bit on);
        char_ch.valid <= 1'b0;
        @(posedge i_clk);
        idle_on = on;
        @(negedge i_clk);
    endtask

    task automatic send_random_string();
        int mode;
        int n_groups;
        int pads;
        int n_extra;
        int pick;
        mode = $urandom_range(0, 99);
        n_groups = $urandom_range(0, 3);
        for (int g = 0; g < n_groups; g++) begin
            pads = (g == n_groups - 1 && mode < 70) ? $urandom_range(0, 2) : 0;
            for (int k = 0; k < 4; k++) begin
                send_char((k < 4 - pads) ? rand_b64() : CHAR_PAD, 1'b0);
            end
        end
        if (mode >= 70 && mode < 85) begin
            n_extra = $urandom_range(1, 3);
            for (int k = 0; k < n_extra; k++) begin
                send_char(rand_b64(), 1'b0);
            end
        end else if (mode >= 85) begin
            n_extra = $urandom_range(1, 6);
            for (int k = 0; k < n_extra; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_char(rand_b64(), 1'b0);
                end else if (pick < 65) begin
                    send_char(CHAR_PAD, 1'b0);
                end else begin
                    send_char(8'($urandom_range(1, 255)), 1'b0);
                end
            end
        end
        send_end();
    endtask

    initial begin
        int first_random;
        i_rst_n = 1'b0;
        char_ch.valid = 1'b0;
        char_ch.character = 8'd0;
        char_ch.terminator = 1'b0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_text("////");
        send_text("TWE=");
        send_text("AA==");
        send_char(8'hFF, 1'b1);
        send_text("=A");
        send_char(8'h00, 1'b1);
        send_text("A===");
        send_end();
        send_text("A*");
        send_end();
        send_text("AB");
        send_char(CHAR_NUL, 1'b0);
        send_text("*A");
        send_char(CHAR_NUL, 1'b0);
        wait_drained();

        // The receiver stalls while a string keeps arriving, so the result
        // queue fills and input ready drops.
        @(posedge i_clk);
        hold_toggle = ~hold_toggle;
        @(negedge i_clk);
        for (int g = 0; g < STALL_GROUPS * 4; g++) begin
            send_char(rand_b64(), 1'b0);
        end
        send_char(8'($urandom), 1'b1);
        wait_drained();

        first_random = sent_chars;
        set_idling(1'b0);
        while (sent_chars - first_random < RANDOM_CHARS / 3) begin
            send_random_string();
        end
        set_idling(1'b1);
        while (sent_chars - first_random < RANDOM_CHARS) begin
            send_random_string();
        end

        wait_drained();
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/b64d_pkg.sv
hw/rtl/b64d_in_if.sv
hw/rtl/b64d_out_if.sv
hw/rtl/b64d_decode.sv
hw/rtl/b64d_fifo.sv
hw/rtl/base64_decoder.sv
tb/b64d_result_checker.sv
tb/tb_base64_decoder.sv
